// File: rtl/core/scwu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwu_pkg: shared types and constants of the congestion window block
// event, entry and recovery records, command codes and reset values
// ----------------------------------------------------------------------------
package scwu_pkg;

  localparam logic [2:0] CMD_SETUP       = 3'd0;
  localparam logic [2:0] CMD_IDLE_DECAY  = 3'd1;
  localparam logic [2:0] CMD_RTO         = 3'd2;
  localparam logic [2:0] CMD_SACK_SLOW   = 3'd3;
  localparam logic [2:0] CMD_SACK_AVOID  = 3'd4;
  localparam logic [2:0] CMD_FAST_RETX   = 3'd5;
  localparam logic [2:0] CMD_EXIT_RECOV  = 3'd6;

  localparam logic [15:0] FLOOR_RESET = 16'd4389;

  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 136;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  dest;
    logic [15:0] mtu;
    logic [31:0] rwnd;
    logic [31:0] acked;
    logic [31:0] out_sack;
    logic [31:0] out_now;
    logic [15:0] chunks;
    logic [31:0] htsn;
  } event_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [31:0] partial;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] point;
  } recov_t;

  typedef struct packed {
    logic [2:0] dest;
    entry_t     entry;
    recov_t     recov;
  } result_t;

endpackage

// File: rtl/core/scwu_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwu_calc: next-state logic for one event
// computes the updated destination entry and association recovery state
// ----------------------------------------------------------------------------
module scwu_calc (
  input  scwu_pkg::event_t evt_i,
  input  logic             present_i,
  input  scwu_pkg::entry_t entry_i,
  input  scwu_pkg::recov_t recov_i,
  input  logic [15:0]      floor_i,
  output scwu_pkg::entry_t entry_o,
  output scwu_pkg::recov_t recov_o
);

  logic [31:0] mtu32, two_mtu, four_mtu, floor32, hi_term, init_win, halved;
  logic [31:0] ss_inc, ss_sum, pa_acc, cw_grow, pa_left;
  logic [32:0] ss_raw, pa_raw, cw_raw;
  logic        grow;

  assign mtu32    = {16'd0, evt_i.mtu};
  assign two_mtu  = {15'd0, evt_i.mtu, 1'b0};
  assign four_mtu = {14'd0, evt_i.mtu, 2'b0};
  assign floor32  = {16'd0, floor_i};

  assign hi_term  = (two_mtu > floor32) ? two_mtu : floor32;
  assign init_win = (four_mtu < hi_term) ? four_mtu : hi_term;
  assign halved   = ((entry_i.cwnd >> 1) > four_mtu) ? (entry_i.cwnd >> 1) : four_mtu;

  // slow start growth, saturating
  assign ss_inc = (evt_i.acked < mtu32) ? evt_i.acked : mtu32;
  assign ss_raw = {1'b0, entry_i.cwnd} + {1'b0, ss_inc};
  assign ss_sum = ss_raw[32] ? '1 : ss_raw[31:0];

  // congestion avoidance
  assign pa_raw  = {1'b0, entry_i.partial} + {1'b0, evt_i.acked};
  assign pa_acc  = pa_raw[32] ? '1 : pa_raw[31:0];
  assign grow    = (pa_acc >= entry_i.cwnd) && (evt_i.out_sack >= entry_i.cwnd);
  assign cw_raw  = {1'b0, entry_i.cwnd} + {1'b0, mtu32};
  assign cw_grow = cw_raw[32] ? '1 : cw_raw[31:0];
  assign pa_left = (pa_acc > cw_grow) ? (pa_acc - cw_grow) : '0;

  always_comb begin
    entry_o = entry_i;
    recov_o = recov_i;
    if (evt_i.command == scwu_pkg::CMD_EXIT_RECOV) begin
      recov_o = '0;
    end else if (present_i) begin
      case (evt_i.command)
        scwu_pkg::CMD_SETUP: begin
          entry_o.cwnd     = init_win;
          entry_o.ssthresh = evt_i.rwnd;
        end
        scwu_pkg::CMD_IDLE_DECAY: begin
          entry_o.cwnd = init_win;
        end
        scwu_pkg::CMD_RTO: begin
          entry_o.ssthresh = halved;
          entry_o.cwnd     = mtu32;
        end
        scwu_pkg::CMD_SACK_SLOW: begin
          if (entry_i.cwnd <= entry_i.ssthresh) begin
            entry_o.cwnd = ss_sum;
          end
        end
        scwu_pkg::CMD_SACK_AVOID: begin
          if (entry_i.cwnd > entry_i.ssthresh && evt_i.chunks != '0) begin
            if (grow) begin
              entry_o.cwnd    = cw_grow;
              entry_o.partial = pa_left;
            end else begin
              entry_o.partial = pa_acc;
            end
          end
          if (evt_i.out_now == '0) begin
            entry_o.partial = '0;
          end
        end
        scwu_pkg::CMD_FAST_RETX: begin
          // halve once per recovery episode
          if (!recov_i.valid) begin
            entry_o.ssthresh = halved;
            if (entry_i.cwnd > halved) begin
              entry_o.cwnd = halved;
            end
            recov_o.valid = 1'b1;
            recov_o.point = evt_i.htsn;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/scwu_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scwu_store: per-destination window state and association recovery point
// register file with a single shared read and write address, cleared at reset
// ----------------------------------------------------------------------------
module scwu_store #(
  parameter int unsigned DESTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       dest_i,
  input  logic             we_i,
  input  scwu_pkg::entry_t entry_i,
  input  scwu_pkg::recov_t recov_i,
  output logic             present_o,
  output scwu_pkg::entry_t entry_o,
  output scwu_pkg::recov_t recov_o
);

  // only eight entries are reachable through the 3-bit index
  localparam int unsigned ENTRIES = (DESTS < 8) ? DESTS : 8;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [3:0]  ENT_CNT = 4'(ENTRIES);

  scwu_pkg::entry_t entry_q [ENTRIES];
  scwu_pkg::recov_t recov_q;
  logic [IDX_W-1:0] idx;

  assign idx       = dest_i[IDX_W-1:0];
  assign present_o = {1'b0, dest_i} < ENT_CNT;
  assign entry_o   = present_o ? entry_q[idx] : '0;
  assign recov_o   = recov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_q[i] <= '0;
      end
      recov_q <= '0;
    end else if (we_i) begin
      if (present_o) begin
        entry_q[idx] <= entry_i;
      end
      recov_q <= recov_i;
    end
  end

endmodule

// File: rtl/core/sctp_congestion_window_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_congestion_window_update: per-destination sctp congestion control
// keeps cwnd, ssthresh and partial bytes acked per destination plus one
// association fast-recovery point, updated by one event per word
// ----------------------------------------------------------------------------
// One event word is taken per clock while the result side is not stalled and
// gives exactly one result word. An event is held in the input register, then
// a single pass through the window update logic writes the destination entry
// and loads the result register, which presents the result word. The
// read-modify-write of the destination register file in that one pass sets
// the rate; an event may use the entry written by the one just before it.
// Destination indexes at or above DESTS report a zero entry and leave their
// entry alone. initial_window_floor is written through cfg_we_i / cfg_wdata_i.
module sctp_congestion_window_update #(
  parameter int unsigned DESTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dest_index, mtu, peer_rwnd, bytes_acked, outstanding_at_sack,
  // outstanding_now, cumack_chunks, highest_tsn, zero pad
  input  logic [scwu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [2:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dest_out, cwnd_out, ssthresh_out, partial_acked_out, in_recovery,
  // recovery_point_out, zero pad
  output logic [scwu_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic [15:0]       floor_q;
  logic              in_v_q, out_v_q, advance;
  scwu_pkg::event_t  evt_q, evt_d;
  scwu_pkg::result_t res_q, res_d;
  scwu_pkg::entry_t  cur_entry, new_entry;
  scwu_pkg::recov_t  cur_recov, new_recov;
  logic              present;

  assign evt_d.command  = s_axis_tuser;
  assign evt_d.dest     = s_axis_tdata[2:0];
  assign evt_d.mtu      = s_axis_tdata[18:3];
  assign evt_d.rwnd     = s_axis_tdata[50:19];
  assign evt_d.acked    = s_axis_tdata[82:51];
  assign evt_d.out_sack = s_axis_tdata[114:83];
  assign evt_d.out_now  = s_axis_tdata[146:115];
  assign evt_d.chunks   = s_axis_tdata[162:147];
  assign evt_d.htsn     = s_axis_tdata[194:163];

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= scwu_pkg::FLOOR_RESET;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      evt_q <= evt_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  scwu_store #(
    .DESTS(DESTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .dest_i   (evt_q.dest),
    .we_i     (advance),
    .entry_i  (new_entry),
    .recov_i  (new_recov),
    .present_o(present),
    .entry_o  (cur_entry),
    .recov_o  (cur_recov)
  );

  scwu_calc u_calc (
    .evt_i    (evt_q),
    .present_i(present),
    .entry_i  (cur_entry),
    .recov_i  (cur_recov),
    .floor_i  (floor_q),
    .entry_o  (new_entry),
    .recov_o  (new_recov)
  );

  always_comb begin
    res_d.dest  = evt_q.dest;
    res_d.entry = present ? new_entry : '0;
    res_d.recov = new_recov;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'd0, res_q.recov.point, res_q.recov.valid,
                          res_q.entry.partial, res_q.entry.ssthresh,
                          res_q.entry.cwnd, res_q.dest};

  // recovery point is only meaningful while recovery is active
  a_point_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_recov.valid |-> cur_recov.point == '0)
    else $error("recovery point set outside recovery");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_v_q)
    else $error("processed word did not reach result register");

  a_exit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && evt_q.command == scwu_pkg::CMD_EXIT_RECOV |=> !cur_recov.valid)
    else $error("exit recovery left recovery active");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !advance |=> in_v_q && $stable(evt_q))
    else $error("stalled input word lost");

endmodule

// File: dv/sctp_congestion_window_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctp_congestion_window_update_tb: self-checking bench for the cwnd block
// drives event words with random gaps, stalls the result side at random,
// and checks every result word against an in-bench window predictor
// ----------------------------------------------------------------------------
module sctp_congestion_window_update_tb;

  localparam logic [2:0]  CMD_UNUSED  = 3'd7;
  localparam int unsigned DEST_COUNT  = 8;
  localparam int unsigned PHASE_ITEMS = 340;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct {
    bit               is_cfg;
    logic [15:0]      floor_val;
    bit               hold;
    int unsigned      gap;
    scwu_pkg::event_t ev;
  } op_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [15:0]                     cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [scwu_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [2:0]                      s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [scwu_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  sctp_congestion_window_update #(
    .DESTS(DEST_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  logic [31:0] cwnd_m    [DEST_COUNT];
  logic [31:0] ssthresh_m[DEST_COUNT];
  logic [31:0] partial_m [DEST_COUNT];
  logic        recov_valid_m;
  logic [31:0] recov_point_m;
  logic [15:0] floor_m;

  op_t               event_q[$];
  scwu_pkg::result_t window_updates_q[$];
  logic [15:0]       dest_mtu[DEST_COUNT];
  int unsigned       errors = 0;
  int unsigned       quiet_cycles = 0;
  bit                watchdog_fired = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic [scwu_pkg::IN_DATA_W-1:0] pack_event(scwu_pkg::event_t ev);
    return {5'd0, ev.htsn, ev.chunks, ev.out_now, ev.out_sack, ev.acked, ev.rwnd,
            ev.mtu, ev.dest};
  endfunction

  function automatic scwu_pkg::event_t unpack_event(logic [scwu_pkg::IN_DATA_W-1:0] d,
                                                    logic [2:0] cmd);
    scwu_pkg::event_t ev;
    ev.command  = cmd;
    ev.dest     = d[2:0];
    ev.mtu      = d[18:3];
    ev.rwnd     = d[50:19];
    ev.acked    = d[82:51];
    ev.out_sack = d[114:83];
    ev.out_now  = d[146:115];
    ev.chunks   = d[162:147];
    ev.htsn     = d[194:163];
    return ev;
  endfunction

  function automatic scwu_pkg::result_t update_window(scwu_pkg::event_t ev);
    logic [31:0]       cw, th, pa, mtu32, four, two, hi, init_win, half, halved;
    scwu_pkg::result_t res;
    cw       = cwnd_m[ev.dest];
    th       = ssthresh_m[ev.dest];
    pa       = partial_m[ev.dest];
    mtu32    = {16'd0, ev.mtu};
    four     = {14'd0, ev.mtu, 2'b00};
    two      = {15'd0, ev.mtu, 1'b0};
    hi       = (two > {16'd0, floor_m}) ? two : {16'd0, floor_m};
    init_win = (four < hi) ? four : hi;
    half     = cw >> 1;
    halved   = (half > four) ? half : four;
    case (ev.command)
      scwu_pkg::CMD_EXIT_RECOV: begin
        recov_valid_m = 1'b0;
        recov_point_m = '0;
      end
      scwu_pkg::CMD_SETUP: begin
        cw = init_win;
        th = ev.rwnd;
      end
      scwu_pkg::CMD_IDLE_DECAY: cw = init_win;
      scwu_pkg::CMD_RTO: begin
        th = halved;
        cw = mtu32;
      end
      scwu_pkg::CMD_SACK_SLOW: begin
        if (cw <= th) cw = sat_add(cw, (ev.acked < mtu32) ? ev.acked : mtu32);
      end
      scwu_pkg::CMD_SACK_AVOID: begin
        if (cw > th && ev.chunks != 16'd0) begin
          pa = sat_add(pa, ev.acked);
          if (pa >= cw && ev.out_sack >= cw) begin
            cw = sat_add(cw, mtu32);
            pa = (pa > cw) ? pa - cw : 32'd0;
          end
        end
        if (ev.out_now == 32'd0) pa = '0;
      end
      scwu_pkg::CMD_FAST_RETX: begin
        // only the first fast retransmit of an episode cuts the window
        if (!recov_valid_m) begin
          th = halved;
          if (cw > th) cw = th;
          recov_valid_m = 1'b1;
          recov_point_m = ev.htsn;
        end
      end
      default: ;
    endcase
    cwnd_m[ev.dest]     = cw;
    ssthresh_m[ev.dest] = th;
    partial_m[ev.dest]  = pa;
    res.dest           = ev.dest;
    res.entry.cwnd     = cw;
    res.entry.ssthresh = th;
    res.entry.partial  = pa;
    res.recov.valid    = recov_valid_m;
    res.recov.point    = recov_valid_m ? recov_point_m : 32'd0;
    return res;
  endfunction

  function automatic scwu_pkg::event_t make_event(logic [2:0] cmd, logic [2:0] d,
                                                  logic [15:0] mtu,
                                                  logic [31:0] rwnd, logic [31:0] acked,
                                                  logic [31:0] osack, logic [31:0] onow,
                                                  logic [15:0] chunks, logic [31:0] htsn);
    scwu_pkg::event_t ev;
    ev.command  = cmd;
    ev.dest     = d;
    ev.mtu      = mtu;
    ev.rwnd     = rwnd;
    ev.acked    = acked;
    ev.out_sack = osack;
    ev.out_now  = onow;
    ev.chunks   = chunks;
    ev.htsn     = htsn;
    return ev;
  endfunction

  task automatic push_word(scwu_pkg::event_t ev, int unsigned gap, bit hold);
    op_t op;
    op.is_cfg    = 1'b0;
    op.floor_val = '0;
    op.hold      = hold;
    op.gap       = gap;
    op.ev        = ev;
    event_q.push_back(op);
  endtask

  task automatic push_floor(logic [15:0] val);
    op_t op;
    op.is_cfg    = 1'b1;
    op.floor_val = val;
    op.hold      = 1'b1;
    op.gap       = 0;
    op.ev        = '0;
    event_q.push_back(op);
  endtask

  function automatic scwu_pkg::event_t random_event();
    int unsigned r;
    logic [2:0]  cmd, d;
    logic [15:0] mtu;
    logic [31:0] rwnd, acked, osack, onow, htsn;
    logic [15:0] chunks;
    r = $urandom_range(0, 99);
    if (r < 6) cmd = scwu_pkg::CMD_SETUP;
    else if (r < 10) cmd = scwu_pkg::CMD_IDLE_DECAY;
    else if (r < 17) cmd = scwu_pkg::CMD_RTO;
    else if (r < 47) cmd = scwu_pkg::CMD_SACK_SLOW;
    else if (r < 82) cmd = scwu_pkg::CMD_SACK_AVOID;
    else if (r < 91) cmd = scwu_pkg::CMD_FAST_RETX;
    else if (r < 99) cmd = scwu_pkg::CMD_EXIT_RECOV;
    else cmd = CMD_UNUSED;
    d = 3'($urandom_range(0, DEST_COUNT - 1));
    // paths mostly keep their mtu, now and then it changes or jumps to an extreme
    if ($urandom_range(0, 99) < 3) dest_mtu[d] = 16'($urandom_range(200, 9000));
    r = $urandom_range(0, 99);
    if (r < 85) mtu = dest_mtu[d];
    else if (r < 88) mtu = 16'd0;
    else if (r < 91) mtu = 16'hFFFF;
    else mtu = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 50) rwnd = $urandom_range(0, 200000);
    else if (r < 92) rwnd = $urandom;
    else if (r < 96) rwnd = 32'hFFFF_FFFF;
    else rwnd = '0;
    r = $urandom_range(0, 99);
    if (r < 70) acked = $urandom_range(0, 3 * int'(mtu));
    else if (r < 92) acked = $urandom_range(0, 200000);
    else acked = $urandom;
    r = $urandom_range(0, 99);
    if (r < 50) osack = $urandom_range(0, 400000);
    else osack = $urandom;
    onow   = ($urandom_range(0, 99) < 20) ? 32'd0 : $urandom;
    r = $urandom_range(0, 99);
    if (r < 15) chunks = 16'd0;
    else if (r < 90) chunks = 16'($urandom_range(1, 64));
    else chunks = 16'($urandom_range(0, 65535));
    htsn   = ($urandom_range(0, 99) < 5) ? 32'd0 : $urandom;
    return make_event(cmd, d, mtu, rwnd, acked, osack, onow, chunks, htsn);
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch expected 0x%08h actual 0x%08h", $time, name, expv, actv);
      errors++;
    end
  endtask

  // driver: one op at a time from event_q
  op_t         cur_op;
  bit          have_op   = 1'b0;
  bit          settle    = 1'b0;
  bit          cfg_pulse = 1'b0;
  int unsigned gap_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
      have_op   = 1'b0;
      settle    = 1'b0;
      cfg_pulse = 1'b0;
      gap_left  = 0;
    end else begin
      cfg_pulse = 1'b0;
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (!have_op && event_q.size() > 0) begin
          cur_op   = event_q.pop_front();
          have_op  = 1'b1;
          gap_left = cur_op.gap;
          settle   = 1'b1;
        end
        if (!have_op) begin
          s_axis_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left--;
        end else if ((cur_op.is_cfg || cur_op.hold) &&
                     (settle || window_updates_q.size() != 0)) begin
          // wait for the block to drain before a register write or a held word
          s_axis_tvalid <= 1'b0;
          settle = 1'b0;
        end else if (cur_op.is_cfg) begin
          s_axis_tvalid <= 1'b0;
          cfg_wdata_i   <= cur_op.floor_val;
          cfg_pulse = 1'b1;
          have_op   = 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_event(cur_op.ev);
          s_axis_tuser  <= cur_op.ev.command;
          have_op = 1'b0;
        end
      end
      cfg_we_i <= cfg_pulse;
    end
  end

  // result side backpressure
  int unsigned ready_hold = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      m_axis_tready <= !m_axis_tready;
      if (m_axis_tready) ready_hold = pick_gap();
      else if ($urandom_range(0, 99) < 80) ready_hold = $urandom_range(1, 10);
      else ready_hold = $urandom_range(50, 300);
    end
  end

  // monitor: predict on accepted events, compare accepted results
  always @(posedge clk_i) begin
    scwu_pkg::result_t exp_res;
    if (rst_ni) begin
      if (cfg_we_i) floor_m = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        window_updates_q.push_back(update_window(unpack_event(s_axis_tdata, s_axis_tuser)));
      if (m_axis_tvalid && m_axis_tready) begin
        if (window_updates_q.size() == 0) begin
          $display("%0t: unexpected result word expected none actual 0x%034h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          exp_res = window_updates_q.pop_front();
          check_field("dest_out", {29'd0, exp_res.dest}, {29'd0, m_axis_tdata[2:0]});
          check_field("cwnd_out", exp_res.entry.cwnd, m_axis_tdata[34:3]);
          check_field("ssthresh_out", exp_res.entry.ssthresh, m_axis_tdata[66:35]);
          check_field("partial_acked_out", exp_res.entry.partial, m_axis_tdata[98:67]);
          check_field("in_recovery", {31'd0, exp_res.recov.valid}, {31'd0, m_axis_tdata[99]});
          check_field("recovery_point_out", exp_res.recov.point, m_axis_tdata[131:100]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) watchdog_fired = 1'b1;
    end
  end

  initial begin
    logic [15:0] phase_floor[5];
    int unsigned burst_left;
    bit          no_gaps;
    for (int i = 0; i < DEST_COUNT; i++) begin
      cwnd_m[i]     = '0;
      ssthresh_m[i] = '0;
      partial_m[i]  = '0;
      dest_mtu[i]   = 16'($urandom_range(500, 9000));
    end
    recov_valid_m = 1'b0;
    recov_point_m = '0;
    floor_m       = scwu_pkg::FLOOR_RESET;

    // directed words at the reset floor
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd0, 16'd1500, 32'hFFFF_FFFF,
                         0, 0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SACK_SLOW, 3'd0, 16'd1500, 0, 32'hFFFF_FFFF,
                         0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SACK_SLOW, 3'd0, 16'd1500, 0, 32'd100,
                         0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_IDLE_DECAY, 3'd0, 16'd0, 0, 0, 0, 0, 0, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd1, 16'hFFFF, 32'd0, 0, 0, 1, 1, 0), 0, 0);
    // partial bytes acked saturates; too little outstanding to grow, then growth
    push_word(make_event(scwu_pkg::CMD_SACK_AVOID, 3'd1, 16'hFFFF, 0, 32'hFFFF_FFFF,
                         32'd0, 32'd1, 16'd1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SACK_AVOID, 3'd1, 16'hFFFF, 0, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'd1, 16'hFFFF, 0), 0, 0);
    // no cumack chunks and nothing left outstanding
    push_word(make_event(scwu_pkg::CMD_SACK_AVOID, 3'd1, 16'hFFFF, 0, 32'd5000,
                         32'hFFFF_FFFF, 32'd0, 16'd0, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_RTO, 3'd1, 16'hFFFF, 0, 0, 0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd2, 16'd9000, 32'd200000,
                         0, 0, 1, 1, 0), 0, 0);
    // recovery that starts at tsn zero, then a second fast retransmit is ignored
    push_word(make_event(scwu_pkg::CMD_FAST_RETX, 3'd2, 16'd9000, 0, 0, 0, 1, 1,
                         32'd0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_FAST_RETX, 3'd3, 16'd1500, 0, 0, 0, 1, 1,
                         32'h1234), 0, 0);
    push_word(make_event(scwu_pkg::CMD_EXIT_RECOV, 3'd7, 16'hFFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                         32'hFFFF_FFFF), 0, 0);
    push_word(make_event(scwu_pkg::CMD_FAST_RETX, 3'd2, 16'd9000, 0, 0, 0, 1, 1,
                         32'hFFFF_FFFF), 0, 0);
    push_word(make_event(CMD_UNUSED, 3'd2, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 0, 0);
    push_word(make_event(scwu_pkg::CMD_EXIT_RECOV, 3'd0, 0, 0, 0, 0, 0, 0, 0), 0, 0);
    // window at or below threshold leaves avoidance alone
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd5, 16'd1500, 32'd100000,
                         0, 0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SACK_AVOID, 3'd5, 16'd1500, 0, 32'd9000,
                         32'd100000, 32'd0, 16'd3, 0), 0, 0);
    push_floor(16'd0);
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd4, 16'd1500, 32'd1000,
                         0, 0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_IDLE_DECAY, 3'd4, 16'd9000, 0, 0, 0, 1, 1, 0), 0, 0);
    push_floor(16'hFFFF);
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd6, 16'd1000, 32'd1000,
                         0, 0, 1, 1, 0), 0, 0);
    push_word(make_event(scwu_pkg::CMD_SETUP, 3'd6, 16'hFFFF, 32'd1000,
                         0, 0, 1, 1, 0), 0, 0);

    // random phases, each under its own floor
    phase_floor[0] = 16'hFFFF;
    phase_floor[1] = 16'($urandom_range(0, 65535));
    phase_floor[2] = 16'd0;
    phase_floor[3] = 16'($urandom_range(1000, 10000));
    phase_floor[4] = scwu_pkg::FLOOR_RESET;
    burst_left = 0;
    no_gaps    = 1'b0;
    for (int p = 0; p < 5; p++) begin
      push_floor(phase_floor[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(20, 60);
          no_gaps    = ($urandom_range(0, 99) < 25);
        end
        burst_left--;
        push_word(random_event(), no_gaps ? 0 : pick_gap(),
                  (n == PHASE_ITEMS / 2) || ($urandom_range(0, 99) < 1));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!watchdog_fired && !(event_q.size() == 0 && !have_op && !s_axis_tvalid &&
                                window_updates_q.size() == 0))
      @(posedge clk_i);
    if (!watchdog_fired) repeat (DRAIN_WAIT) @(posedge clk_i);

    if (watchdog_fired) begin
      $display("sctp_congestion_window_update verification failed");
    end else if (errors == 0 && window_updates_q.size() == 0) begin
      $display("sctp_congestion_window_update verification clean");
    end else begin
      $display("sctp_congestion_window_update verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/scwu_pkg.sv
rtl/core/scwu_calc.sv
rtl/core/scwu_store.sv
rtl/core/sctp_congestion_window_update.sv
dv/sctp_congestion_window_update_tb.sv
